FILE: rtl/cfs_pkg.sv
// Package for the contactor feedback supervisor: widths, state, command and fault codes,
// register map and the structs used by the top level and the control core.
// No dependencies.
`default_nettype none

package cfs_pkg;

  // Field widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StateW   = 3;
  localparam int unsigned FaultW   = 3;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ElapsedW = 17;

  // APB register file
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [RegIdxW-1:0] RegTimeout  = 2'd1;
  localparam logic [RegIdxW-1:0] RegAllowExt = 2'd2;
  localparam logic [RegIdxW-1:0] RegClosedLv = 2'd3;

  localparam logic [TimeW-1:0] DebounceRst = 16'd50;
  localparam logic [TimeW-1:0] TimeoutRst  = 16'd500;
  localparam logic             AllowExtRst = 1'b0;
  localparam logic             ClosedLvRst = 1'b1;

  // Controller states
  localparam logic [StateW-1:0] StInit    = 3'd0;
  localparam logic [StateW-1:0] StOpen    = 3'd1;
  localparam logic [StateW-1:0] StClosing = 3'd2;
  localparam logic [StateW-1:0] StClosed  = 3'd3;
  localparam logic [StateW-1:0] StOpening = 3'd4;
  localparam logic [StateW-1:0] StFault   = 3'd5;

  // Commands
  localparam logic [CmdW-1:0] CmdTick    = 3'd0;
  localparam logic [CmdW-1:0] CmdInit    = 3'd1;
  localparam logic [CmdW-1:0] CmdClose   = 3'd2;
  localparam logic [CmdW-1:0] CmdOpen    = 3'd3;
  localparam logic [CmdW-1:0] CmdSetMode = 3'd4;

  // Fault codes
  localparam logic [FaultW-1:0] FcNone         = 3'd0;
  localparam logic [FaultW-1:0] FcInitClosed   = 3'd1;
  localparam logic [FaultW-1:0] FcUnexpClosed  = 3'd2;
  localparam logic [FaultW-1:0] FcUnexpOpen    = 3'd3;
  localparam logic [FaultW-1:0] FcOpenTimeout  = 3'd4;
  localparam logic [FaultW-1:0] FcCloseTimeout = 3'd5;

  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  // Configuration seen by the core
  typedef struct packed {
    logic [TimeW-1:0] debounce;
    logic [TimeW-1:0] timeout;
    logic             allow_ext;
    logic             closed_level;
  } cfg_t;

  // Result word of one step
  typedef struct packed {
    logic [StateW-1:0] state;
    logic              coil;
    logic [FaultW-1:0] fault;
    logic              fb_closed;
  } res_t;

  // Supervisor context
  typedef struct packed {
    logic [StateW-1:0]   st;
    logic                drv;
    logic [FaultW-1:0]   flt;
    logic [ElapsedW-1:0] el;
    logic                off;
  } ctx_t;

endpackage

`default_nettype wire

FILE: rtl/cfs_if.sv
// Valid/ready channel interfaces for the supervisor's command and result words.
// Depends on cfs_pkg for field widths.
`default_nettype none

interface cfs_in_if;
  logic                      valid;
  logic                      ready;
  logic [cfs_pkg::CmdW-1:0]  command;
  logic                      feedback_level;
  logic                      disable_feedback;

  modport source (output valid, command, feedback_level, disable_feedback, input ready);
  modport sink   (input valid, command, feedback_level, disable_feedback, output ready);
endinterface

interface cfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [cfs_pkg::StateW-1:0]  contactor_state;
  logic                        coil_drive;
  logic [cfs_pkg::FaultW-1:0]  fault_code;
  logic                        feedback_closed;

  modport source (output valid, contactor_state, coil_drive, fault_code, feedback_closed,
                  input ready);
  modport sink   (input valid, contactor_state, coil_drive, fault_code, feedback_closed,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/cfs_ctrl.sv
// Supervisor core: context registers and the one-step next-state logic per command word.
// Depends on cfs_pkg.
`default_nettype none

module cfs_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [cfs_pkg::CmdW-1:0]  command_i,
  input  wire logic                      feedback_level_i,
  input  wire logic                      disable_feedback_i,
  input  wire cfs_pkg::cfg_t             cfg_i,
  output cfs_pkg::res_t                  res_o
);

  cfs_pkg::ctx_t ctx_q, ctx_d;
  logic          fb_closed;

  // State change restarts the elapsed counter
  function automatic cfs_pkg::ctx_t go_state(cfs_pkg::ctx_t c,
                                             logic [cfs_pkg::StateW-1:0] s);
    cfs_pkg::ctx_t r;
    r = c;
    if (s != c.st) r.el = '0;
    r.st = s;
    return r;
  endfunction

  function automatic cfs_pkg::ctx_t go_fault(cfs_pkg::ctx_t c,
                                             logic [cfs_pkg::FaultW-1:0] code);
    cfs_pkg::ctx_t r;
    r = go_state(c, cfs_pkg::StFault);
    r.drv = 1'b0;
    r.flt = code;
    return r;
  endfunction

  // Initialise: only acts from init
  function automatic cfs_pkg::ctx_t do_init(cfs_pkg::ctx_t c, logic fbc, logic allow);
    cfs_pkg::ctx_t r;
    r = c;
    if (c.st == cfs_pkg::StInit) begin
      r.flt = cfs_pkg::FcNone;
      r.drv = 1'b0;
      if (r.off || !fbc) begin
        r = go_state(r, cfs_pkg::StOpen);
      end else if (allow) begin
        r = go_state(r, cfs_pkg::StClosed);
      end else begin
        r = go_fault(r, cfs_pkg::FcInitClosed);
      end
    end
    return r;
  endfunction

  // Millisecond tick: count, then supervise on the new count
  function automatic cfs_pkg::ctx_t do_tick(cfs_pkg::ctx_t c, logic fbc, cfs_pkg::cfg_t cfg);
    cfs_pkg::ctx_t r;
    logic          past_to, past_db;
    r = c;
    if (r.el != cfs_pkg::ElapsedMax) r.el = r.el + 1'b1;
    past_to = (r.el > {1'b0, cfg.timeout});
    past_db = (r.el > {1'b0, cfg.debounce});
    if (!r.off) begin
      case (r.st)
        cfs_pkg::StOpen: begin
          if (fbc) r = cfg.allow_ext ? go_state(r, cfs_pkg::StClosed)
                                     : go_fault(r, cfs_pkg::FcUnexpClosed);
        end
        cfs_pkg::StClosed: begin
          if (!fbc) r = cfg.allow_ext ? go_state(r, cfs_pkg::StOpen)
                                      : go_fault(r, cfs_pkg::FcUnexpOpen);
        end
        cfs_pkg::StOpening: begin
          if (past_to) r = go_fault(r, cfs_pkg::FcOpenTimeout);
          else if (past_db && !fbc) r = go_state(r, cfs_pkg::StOpen);
        end
        cfs_pkg::StClosing: begin
          if (past_to) r = go_fault(r, cfs_pkg::FcCloseTimeout);
          else if (past_db && fbc) r = go_state(r, cfs_pkg::StClosed);
        end
        cfs_pkg::StFault: begin
          r.drv = 1'b0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  assign fb_closed = (feedback_level_i == cfg_i.closed_level);

  // Next context for the word being applied
  always_comb begin
    ctx_d = ctx_q;
    unique case (command_i)
      cfs_pkg::CmdTick: ctx_d = do_tick(ctx_q, fb_closed, cfg_i);
      cfs_pkg::CmdInit: ctx_d = do_init(ctx_q, fb_closed, cfg_i.allow_ext);
      cfs_pkg::CmdClose: begin
        if (ctx_q.off) begin
          ctx_d     = go_state(ctx_q, cfs_pkg::StClosed);
          ctx_d.drv = 1'b1;
          ctx_d.el  = '0;
          ctx_d.flt = cfs_pkg::FcNone;
        end else if (ctx_q.st == cfs_pkg::StOpen || ctx_q.st == cfs_pkg::StOpening) begin
          ctx_d     = go_state(ctx_q, cfs_pkg::StClosing);
          ctx_d.drv = 1'b1;
        end
      end
      cfs_pkg::CmdOpen: begin
        if (ctx_q.off) begin
          ctx_d     = go_state(ctx_q, cfs_pkg::StOpen);
          ctx_d.drv = 1'b0;
          ctx_d.el  = '0;
          ctx_d.flt = cfs_pkg::FcNone;
        end else if (ctx_q.st == cfs_pkg::StClosed || ctx_q.st == cfs_pkg::StClosing) begin
          ctx_d     = go_state(ctx_q, cfs_pkg::StOpening);
          ctx_d.drv = 1'b0;
        end
      end
      cfs_pkg::CmdSetMode: begin
        if (disable_feedback_i != ctx_q.off) begin
          ctx_d     = ctx_q;
          ctx_d.off = disable_feedback_i;
          ctx_d.flt = cfs_pkg::FcNone;
          if (disable_feedback_i) begin
            ctx_d    = go_state(ctx_d, (ctx_q.drv == cfg_i.closed_level) ?
                                       cfs_pkg::StClosed : cfs_pkg::StOpen);
            ctx_d.el = '0;
          end else begin
            ctx_d = go_state(ctx_d, cfs_pkg::StInit);
            ctx_d = do_init(ctx_d, fb_closed, cfg_i.allow_ext);
          end
        end
      end
      default: ctx_d = ctx_q;
    endcase
  end

  // Context registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.st  <= cfs_pkg::StInit;
      ctx_q.drv <= 1'b0;
      ctx_q.flt <= cfs_pkg::FcNone;
      ctx_q.el  <= '0;
      ctx_q.off <= 1'b0;
    end else if (step_i) begin
      ctx_q <= ctx_d;
    end
  end

  assign res_o.state     = ctx_d.st;
  assign res_o.coil      = ctx_d.drv;
  assign res_o.fault     = ctx_d.flt;
  assign res_o.fb_closed = fb_closed;

  // Fault state and a stored fault code go together
  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.st == cfs_pkg::StFault) == (ctx_q.flt != cfs_pkg::FcNone))
    else $error("fault code and fault state disagree");

  // Coil never energised in fault
  a_fault_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.st == cfs_pkg::StFault) |-> !ctx_q.drv)
    else $error("coil driven in fault state");

  // Closing always drives the coil
  a_closing_coil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.st == cfs_pkg::StClosing) |-> ctx_q.drv)
    else $error("coil off while closing");

  // Counter restarts on a state change
  a_el_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && ctx_d.st != ctx_q.st) |=> (ctx_q.el == '0))
    else $error("elapsed counter not restarted on state change");

endmodule

`default_nettype wire

FILE: rtl/contactor_feedback_supervisor.sv
// Top level of the contactor feedback supervisor: APB register file, input word stage,
// result register. Depends on cfs_pkg, cfs_if (cfs_in_if, cfs_out_if) and cfs_ctrl.
//
//   channel | dir | handshake       | payload
//   in_i    | in  | valid/ready     | command, feedback_level, disable_feedback
//   out_o   | out | valid/ready     | contactor_state, coil_drive, fault_code, feedback_closed
//   apb     | in  | psel/penable    | paddr, pwdata -> debounce, timeout, allow_ext, closed_lv
//
// One word per cycle sustained while out_o is not stalled. Each word passes the input stage
// register, then the supervisor step into the result register. One result per input word.
// The input stage advances whenever the result register is empty or being taken, so
// a stalled output holds one word in each stage before in_i.ready drops.
// Reset (rst_ni low, async) clears both stages, the supervisor to init and the
// registers to debounce 50, timeout 500, external control off, closed level 1.
`default_nettype none

module contactor_feedback_supervisor (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  cfs_in_if.sink                                 in_i,
  cfs_out_if.source                              out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cfs_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [cfs_pkg::ApbDataW-1:0]      pwdata,
  output logic [cfs_pkg::ApbDataW-1:0]           prdata,
  output logic                                   pready
);

  cfs_pkg::cfg_t cfg_q;
  logic [cfs_pkg::RegIdxW-1:0] reg_idx;
  logic                        apb_wr;

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[cfs_pkg::RegIdxW+1:2];
  assign apb_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce     <= cfs_pkg::DebounceRst;
      cfg_q.timeout      <= cfs_pkg::TimeoutRst;
      cfg_q.allow_ext    <= cfs_pkg::AllowExtRst;
      cfg_q.closed_level <= cfs_pkg::ClosedLvRst;
    end else if (apb_wr) begin
      unique case (reg_idx)
        cfs_pkg::RegDebounce: cfg_q.debounce     <= pwdata[cfs_pkg::TimeW-1:0];
        cfs_pkg::RegTimeout:  cfg_q.timeout      <= pwdata[cfs_pkg::TimeW-1:0];
        cfs_pkg::RegAllowExt: cfg_q.allow_ext    <= pwdata[0];
        cfs_pkg::RegClosedLv: cfg_q.closed_level <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cfs_pkg::RegDebounce: prdata[cfs_pkg::TimeW-1:0] = cfg_q.debounce;
      cfs_pkg::RegTimeout:  prdata[cfs_pkg::TimeW-1:0] = cfg_q.timeout;
      cfs_pkg::RegAllowExt: prdata[0] = cfg_q.allow_ext;
      cfs_pkg::RegClosedLv: prdata[0] = cfg_q.closed_level;
      default: prdata = '0;
    endcase
  end

  // Input word stage
  logic                      in_vld_q;
  logic [cfs_pkg::CmdW-1:0]  cmd_q;
  logic                      fb_q;
  logic                      dis_q;
  logic                      step;

  assign step       = in_vld_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.command;
      fb_q  <= in_i.feedback_level;
      dis_q <= in_i.disable_feedback;
    end
  end

  // Supervisor step
  cfs_pkg::res_t res;

  cfs_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .command_i          (cmd_q),
    .feedback_level_i   (fb_q),
    .disable_feedback_i (dis_q),
    .cfg_i              (cfg_q),
    .res_o              (res)
  );

  // Result register
  logic          out_vld_q;
  cfs_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.contactor_state = res_q.state;
  assign out_o.coil_drive      = res_q.coil;
  assign out_o.fault_code      = res_q.fault;
  assign out_o.feedback_closed = res_q.fb_closed;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for contactor_feedback_supervisor: APB setup, command words on in_i,
// result words on out_o checked against directed values or a built-in supervisor predictor.
// Depends on cfs_pkg, cfs_if and the supervisor RTL.

module testbench;

  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 1_000_000;
  localparam int MaxPrinted = 100;

  // Highest command code; codes above CmdSetMode are spare and must be ignored
  localparam logic [cfs_pkg::CmdW-1:0] CmdSpareTop = 3'd7;

  // Predicted result word
  typedef struct packed {
    logic [cfs_pkg::StateW-1:0] state;
    logic                       coil;
    logic [cfs_pkg::FaultW-1:0] fault;
    logic                       fbc;
  } sup_out_t;

  // Predictor copy of the supervisor context
  typedef struct packed {
    logic [cfs_pkg::StateW-1:0]   st;
    logic                         drv;
    logic [cfs_pkg::FaultW-1:0]   flt;
    logic [cfs_pkg::ElapsedW-1:0] el;
    logic                         off;
  } sup_state_t;

  typedef struct packed {
    logic [cfs_pkg::CmdW-1:0] cmd;
    logic                     fb;
    logic                     dis;
    logic                     typed;
    sup_out_t                 want;
  } dir_row_t;

  typedef struct {
    int db;
    int to;
    int ext;
    int cl;
    int in_idle;
    int out_stall;
    int tick_pct;
    int items;
  } phase_t;

  localparam sup_out_t NoWord = '0;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [cfs_pkg::ApbAddrW-1:0] paddr;
  logic [cfs_pkg::ApbDataW-1:0] pwdata;
  logic [cfs_pkg::ApbDataW-1:0] prdata;
  logic pready;

  cfs_in_if  in_ch ();
  cfs_out_if out_ch ();

  contactor_feedback_supervisor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor state and configuration
  sup_state_t     sup;
  logic [cfs_pkg::TimeW-1:0] c_debounce, c_timeout;
  logic           c_ext, c_closed_lv;

  sup_out_t    expected_words[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  // Contact model for the random part
  logic contact_closed = 1'b0;
  logic coil_seen = 1'b0;
  logic stuck = 1'b0;

  // Directed words; the want column holds values read straight off the spec
  dir_row_t dir_rows [25] = '{
    '{cfs_pkg::CmdTick,    1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StInit,   1'b0, cfs_pkg::FcNone,       1'b0}},
    '{cfs_pkg::CmdOpen,    1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StInit,   1'b0, cfs_pkg::FcNone,       1'b0}},
    '{cfs_pkg::CmdClose,   1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StInit,   1'b0, cfs_pkg::FcNone,       1'b0}},
    '{CmdSpareTop,         1'b1, 1'b1, 1'b1,
      '{cfs_pkg::StInit,   1'b0, cfs_pkg::FcNone,       1'b1}},
    '{cfs_pkg::CmdInit,    1'b1, 1'b0, 1'b1,
      '{cfs_pkg::StFault,  1'b0, cfs_pkg::FcInitClosed, 1'b1}},
    '{cfs_pkg::CmdTick,    1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StFault,  1'b0, cfs_pkg::FcInitClosed, 1'b0}},
    '{cfs_pkg::CmdInit,    1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StFault,  1'b0, cfs_pkg::FcInitClosed, 1'b0}},
    '{cfs_pkg::CmdSetMode, 1'b0, 1'b1, 1'b1,
      '{cfs_pkg::StOpen,   1'b0, cfs_pkg::FcNone,       1'b0}},
    '{cfs_pkg::CmdSetMode, 1'b1, 1'b1, 1'b1,
      '{cfs_pkg::StOpen,   1'b0, cfs_pkg::FcNone,       1'b1}},
    '{cfs_pkg::CmdTick,    1'b1, 1'b0, 1'b1,
      '{cfs_pkg::StOpen,   1'b0, cfs_pkg::FcNone,       1'b1}},
    '{cfs_pkg::CmdClose,   1'b0, 1'b0, 1'b1,
      '{cfs_pkg::StClosed, 1'b1, cfs_pkg::FcNone,       1'b0}},
    '{cfs_pkg::CmdInit,    1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdOpen,    1'b1, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdClose,   1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdSetMode, 1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdClose,   1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdOpen,    1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdClose,   1'b1, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdTick,    1'b1, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdOpen,    1'b1, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdTick,    1'b0, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdSetMode, 1'b1, 1'b1, 1'b0, NoWord},
    '{cfs_pkg::CmdClose,   1'b1, 1'b0, 1'b0, NoWord},
    '{cfs_pkg::CmdSetMode, 1'b1, 1'b0, 1'b1,
      '{cfs_pkg::StFault,  1'b0, cfs_pkg::FcInitClosed, 1'b1}},
    '{cfs_pkg::CmdSetMode, 1'b0, 1'b1, 1'b0, NoWord}
  };

  // Settings per random phase; db < 0 picks a small random setting
  phase_t phases [7] = '{
    '{50,    500, 0, 1,  0,  0, 97, 300},
    '{2,       6, 1, 0, 74,  0, 75, 200},
    '{0,       0, 0, 1,  0, 74, 75, 150},
    '{3,      12, 1, 1, 26, 26, 75, 200},
    '{65535,   4, 0, 0, 74,  0, 75, 100},
    '{-1,      0, 0, 0,  0, 74, 75, 150},
    '{-1,      0, 0, 0, 26, 26, 75, 150}
  };

  // ---------------- predictor ----------------

  function automatic void sup_goto(input logic [cfs_pkg::StateW-1:0] s);
    if (s != sup.st) sup.el = '0;
    sup.st = s;
  endfunction

  function automatic void sup_fault(input logic [cfs_pkg::FaultW-1:0] code);
    sup_goto(cfs_pkg::StFault);
    sup.drv = 1'b0;
    sup.flt = code;
  endfunction

  function automatic void sup_initialise(input logic fbc);
    if (sup.st != cfs_pkg::StInit) return;
    sup.flt = cfs_pkg::FcNone;
    sup.drv = 1'b0;
    if (sup.off) sup_goto(cfs_pkg::StOpen);
    else if (fbc) begin
      if (c_ext) sup_goto(cfs_pkg::StClosed);
      else sup_fault(cfs_pkg::FcInitClosed);
    end else sup_goto(cfs_pkg::StOpen);
  endfunction

  function automatic void sup_tick(input logic fbc);
    if (sup.el != '1) sup.el = sup.el + 1'b1;
    if (sup.off) return;
    case (sup.st)
      cfs_pkg::StOpen: begin
        if (fbc) begin
          if (c_ext) sup_goto(cfs_pkg::StClosed);
          else sup_fault(cfs_pkg::FcUnexpClosed);
        end
      end
      cfs_pkg::StClosed: begin
        if (!fbc) begin
          if (c_ext) sup_goto(cfs_pkg::StOpen);
          else sup_fault(cfs_pkg::FcUnexpOpen);
        end
      end
      cfs_pkg::StOpening: begin
        if (sup.el > c_timeout) sup_fault(cfs_pkg::FcOpenTimeout);
        else if (sup.el > c_debounce && !fbc) sup_goto(cfs_pkg::StOpen);
      end
      cfs_pkg::StClosing: begin
        if (sup.el > c_timeout) sup_fault(cfs_pkg::FcCloseTimeout);
        else if (sup.el > c_debounce && fbc) sup_goto(cfs_pkg::StClosed);
      end
      cfs_pkg::StFault: sup.drv = 1'b0;
      default: ;
    endcase
  endfunction

  // Applies one command word and returns the word the block should send back
  function automatic sup_out_t supervise_word(input logic [cfs_pkg::CmdW-1:0] cmd,
                                              input logic fb, input logic dis);
    logic     fbc;
    sup_out_t o;
    fbc = (fb == c_closed_lv);
    case (cmd)
      cfs_pkg::CmdTick: sup_tick(fbc);
      cfs_pkg::CmdInit: sup_initialise(fbc);
      cfs_pkg::CmdClose: begin
        if (sup.off) begin
          sup.drv = 1'b1;
          sup_goto(cfs_pkg::StClosed);
          sup.el  = '0;
          sup.flt = cfs_pkg::FcNone;
        end else if (sup.st == cfs_pkg::StOpen || sup.st == cfs_pkg::StOpening) begin
          sup_goto(cfs_pkg::StClosing);
          sup.drv = 1'b1;
        end
      end
      cfs_pkg::CmdOpen: begin
        if (sup.off) begin
          sup.drv = 1'b0;
          sup_goto(cfs_pkg::StOpen);
          sup.el  = '0;
          sup.flt = cfs_pkg::FcNone;
        end else if (sup.st == cfs_pkg::StClosed || sup.st == cfs_pkg::StClosing) begin
          sup_goto(cfs_pkg::StOpening);
          sup.drv = 1'b0;
        end
      end
      cfs_pkg::CmdSetMode: begin
        if (dis != sup.off) begin
          sup.off = dis;
          sup.flt = cfs_pkg::FcNone;
          if (dis) begin
            sup_goto((sup.drv == c_closed_lv) ? cfs_pkg::StClosed : cfs_pkg::StOpen);
            sup.el = '0;
          end else begin
            sup_goto(cfs_pkg::StInit);
            sup_initialise(fbc);
          end
        end
      end
      default: ;
    endcase
    o.state = sup.st;
    o.coil  = sup.drv;
    o.fault = sup.flt;
    o.fbc   = fbc;
    return o;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted)
      $display("mismatch @%0d: %s got %0h want %0h", cycle_cnt, what, got, want);
  endtask

  task automatic check_word();
    sup_out_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with none pending", 32'd0, 32'd0);
      return;
    end
    want = expected_words.pop_front();
    if (out_ch.contactor_state !== want.state)
      report_mismatch("contactor_state", 32'(out_ch.contactor_state), 32'(want.state));
    if (out_ch.coil_drive !== want.coil)
      report_mismatch("coil_drive", 32'(out_ch.coil_drive), 32'(want.coil));
    if (out_ch.fault_code !== want.fault)
      report_mismatch("fault_code", 32'(out_ch.fault_code), 32'(want.fault));
    if (out_ch.feedback_closed !== want.fbc)
      report_mismatch("feedback_closed", 32'(out_ch.feedback_closed), 32'(want.fbc));
  endtask

  // Result sink with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- APB ----------------

  task automatic apb_write(input logic [cfs_pkg::RegIdxW-1:0] idx,
                           input logic [cfs_pkg::ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cfs_pkg::RegDebounce: c_debounce  = val[cfs_pkg::TimeW-1:0];
      cfs_pkg::RegTimeout:  c_timeout   = val[cfs_pkg::TimeW-1:0];
      cfs_pkg::RegAllowExt: c_ext       = val[0];
      cfs_pkg::RegClosedLv: c_closed_lv = val[0];
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input logic [cfs_pkg::RegIdxW-1:0] idx,
                                input logic [cfs_pkg::ApbDataW-1:0] want);
    logic [cfs_pkg::ApbDataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    // sample mid-cycle, ahead of the completing edge
    do @(negedge clk_i); while (!pready);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch($sformatf("register %0d readback", idx), got, want);
  endtask

  task automatic check_regs();
    apb_read_check(cfs_pkg::RegDebounce, cfs_pkg::ApbDataW'(c_debounce));
    apb_read_check(cfs_pkg::RegTimeout,  cfs_pkg::ApbDataW'(c_timeout));
    apb_read_check(cfs_pkg::RegAllowExt, cfs_pkg::ApbDataW'(c_ext));
    apb_read_check(cfs_pkg::RegClosedLv, cfs_pkg::ApbDataW'(c_closed_lv));
  endtask

  task automatic set_config(input logic [cfs_pkg::TimeW-1:0] db,
                            input logic [cfs_pkg::TimeW-1:0] to,
                            input logic ext, input logic cl);
    apb_write(cfs_pkg::RegDebounce, cfs_pkg::ApbDataW'(db));
    apb_write(cfs_pkg::RegTimeout,  cfs_pkg::ApbDataW'(to));
    apb_write(cfs_pkg::RegAllowExt, cfs_pkg::ApbDataW'(ext));
    apb_write(cfs_pkg::RegClosedLv, cfs_pkg::ApbDataW'(cl));
    check_regs();
  endtask

  // ---------------- command words ----------------

  // Offers one word, waits for it to be taken, then books its expected result
  task automatic send_word(input logic [cfs_pkg::CmdW-1:0] cmd, input logic fb,
                           input logic dis, input logic typed, input sup_out_t want);
    sup_out_t pred;
    while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.command          <= cmd;
    in_ch.feedback_level   <= fb;
    in_ch.disable_feedback <= dis;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = supervise_word(cmd, fb, dis);
    expected_words.push_back(typed ? want : pred);
  endtask

  // Mostly ticks with a contact that follows the coil; some noise and stuck moves
  task automatic send_random_word(input int unsigned tick_pct);
    logic [cfs_pkg::CmdW-1:0] cmd;
    logic                     fb, dis;
    int unsigned              r;
    r   = $urandom_range(0, 99);
    dis = 1'($urandom_range(0, 1));
    if (!sup.off && sup.st == cfs_pkg::StInit && r < 40) cmd = cfs_pkg::CmdInit;
    else if (sup.st == cfs_pkg::StFault && r < 15) begin
      cmd = cfs_pkg::CmdSetMode;
      dis = ~sup.off;
    end else if (sup.off && r < 5) begin
      cmd = cfs_pkg::CmdSetMode;
      dis = 1'b0;
    end else if ($urandom_range(0, 99) < tick_pct) cmd = cfs_pkg::CmdTick;
    else begin
      case ($urandom_range(0, 9))
        0, 1, 2: cmd = cfs_pkg::CmdClose;
        3, 4, 5: cmd = cfs_pkg::CmdOpen;
        6:       cmd = cfs_pkg::CmdInit;
        7, 8:    cmd = cfs_pkg::CmdSetMode;
        default: cmd = CmdSpareTop - cfs_pkg::CmdW'($urandom_range(0, 2));
      endcase
    end
    // contact lags the coil; one move in ten never completes
    if (sup.drv != coil_seen) begin
      coil_seen = sup.drv;
      stuck = ($urandom_range(0, 9) == 0);
    end
    if (cmd == cfs_pkg::CmdTick && contact_closed != sup.drv && !stuck &&
        $urandom_range(0, 3) == 0)
      contact_closed = sup.drv;
    fb = contact_closed ? c_closed_lv : ~c_closed_lv;
    if ($urandom_range(0, 49) == 0) fb = ~fb;
    send_word(cmd, fb, dis, 1'b0, NoWord);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------- sequence ----------------

  initial begin
    phase_t ph;
    rst_ni                 <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.command          <= cfs_pkg::CmdTick;
    in_ch.feedback_level   <= 1'b0;
    in_ch.disable_feedback <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    sup         = '{cfs_pkg::StInit, 1'b0, cfs_pkg::FcNone, '0, 1'b0};
    c_debounce  = cfs_pkg::DebounceRst;
    c_timeout   = cfs_pkg::TimeoutRst;
    c_ext       = cfs_pkg::AllowExtRst;
    c_closed_lv = cfs_pkg::ClosedLvRst;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the register file
    check_regs();

    // directed words under reset settings
    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].fb, dir_rows[i].dis, dir_rows[i].typed,
                dir_rows[i].want);
    drain();

    // random phases over several settings and idling patterns
    foreach (phases[p]) begin
      ph = phases[p];
      if (ph.db < 0) begin
        ph.db  = $urandom_range(0, 6);
        ph.to  = $urandom_range(ph.db, 40);
        ph.ext = $urandom_range(0, 1);
        ph.cl  = $urandom_range(0, 1);
      end
      set_config(cfs_pkg::TimeW'(ph.db), cfs_pkg::TimeW'(ph.to), ph.ext[0], ph.cl[0]);
      in_idle_pct   = ph.in_idle;
      out_stall_pct = ph.out_stall;
      repeat (ph.items) send_random_word(ph.tick_pct);
      drain();
    end

    // widest timers: closing holds, neither confirm nor timeout is reached
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_config('1, '1, 1'b0, 1'b1);
    if (!sup.off) send_word(cfs_pkg::CmdSetMode, 1'b0, 1'b1, 1'b0, NoWord);
    send_word(cfs_pkg::CmdSetMode, 1'b0, 1'b0, 1'b0, NoWord);
    send_word(cfs_pkg::CmdClose, 1'b0, 1'b0, 1'b0, NoWord);
    repeat (40) send_word(cfs_pkg::CmdTick, 1'b1, 1'b0, 1'b0, NoWord);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/cfs_pkg.sv
rtl/cfs_if.sv
rtl/cfs_ctrl.sv
rtl/contactor_feedback_supervisor.sv
tb/testbench.sv
